// File: hw/rtl/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg - shared types and constants of the SPI NOR flash slave
// Command codes, register map, reset values, the controller state type and the store request.
// ----------------------------------------------------------------------------
`default_nettype none

package sfs_pkg;

  // Command codes
  localparam logic [7:0] CMD_WREN = 8'h06;
  localparam logic [7:0] CMD_RDID = 8'h9F;
  localparam logic [7:0] CMD_READ = 8'h03;
  localparam logic [7:0] CMD_PP   = 8'h02;
  localparam logic [7:0] CMD_SE   = 8'h20;
  localparam logic [7:0] CMD_RDSR = 8'h05;

  // Register map (word index)
  localparam logic [0:0] REG_DEVICE_ID = 1'b0;

  localparam logic [23:0] DEVICE_ID_RST = 24'hC84015;
  localparam logic [24:0] OFFSET_MAX    = 25'h1FF_FFFF;
  localparam logic [7:0]  ERASED_BYTE   = 8'hFF;
  localparam logic [7:0]  STATUS_BYTE   = 8'h00;
  localparam logic [23:0] SECTOR_MASK   = 24'hFFF000;
  localparam logic [23:0] PAGE_MASK     = 24'hFFFF00;
  localparam int unsigned SECTOR_BYTES  = 4096;

  typedef enum logic [1:0] {
    S_FILL,
    S_IDLE,
    S_RESP
  } sfs_state_e;

  // Store access request from the controller
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic fill_start;
  } sfs_ctl_t;

endpackage : sfs_pkg

`default_nettype wire

// File: hw/rtl/sfs_store.sv
// ----------------------------------------------------------------------------
// sfs_store - flash array with fill engine
// Byte-wide simple dual-port memory, registered read. The fill engine sweeps
// erased bytes over the whole array after reset and over a sector on request.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_store import sfs_pkg::*; #(
  parameter int unsigned Depth = 2097152,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire sfs_ctl_t      ctl_i,
  input  wire logic [AW-1:0] raddr_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic [AW-1:0] fill_base_i,
  output logic [7:0]         rdata_o,
  output logic               fill_busy_o
);

  logic [7:0]    mem [Depth];
  logic [7:0]    rdata_q;
  logic          fill_busy_q, fill_busy_d;
  logic [AW-1:0] fill_ptr_q, fill_ptr_d;
  logic [AW-1:0] fill_last_q, fill_last_d;
  logic [AW:0]   sect_end;
  localparam logic [AW:0] LastEntry = (AW+1)'(Depth - 1);

  // last entry of a sector; the fill clips it at the end of the array
  assign sect_end = {1'b0, fill_base_i} + (AW+1)'(SECTOR_BYTES - 1);

  always_comb begin
    fill_busy_d = fill_busy_q;
    fill_ptr_d  = fill_ptr_q;
    fill_last_d = fill_last_q;
    if (fill_busy_q) begin
      if (fill_ptr_q == fill_last_q) begin
        fill_busy_d = 1'b0;
      end else begin
        fill_ptr_d = fill_ptr_q + AW'(1);
      end
    end else if (ctl_i.fill_start) begin
      fill_busy_d = 1'b1;
      fill_ptr_d  = fill_base_i;
      fill_last_d = (sect_end > LastEntry) ? LastEntry[AW-1:0] : sect_end[AW-1:0];
    end
  end

  // reset starts a full clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_busy_q <= 1'b1;
      fill_ptr_q  <= '0;
      fill_last_q <= LastEntry[AW-1:0];
    end else begin
      fill_busy_q <= fill_busy_d;
      fill_ptr_q  <= fill_ptr_d;
      fill_last_q <= fill_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill_busy_q) begin
      mem[fill_ptr_q] <= ERASED_BYTE;
    end else if (ctl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o     = rdata_q;
  assign fill_busy_o = fill_busy_q;

endmodule : sfs_store

`default_nettype wire

// File: hw/rtl/spi_nor_flash_slave_unit.sv
// ----------------------------------------------------------------------------
// spi_nor_flash_slave_unit - byte-level SPI NOR flash slave
// Decodes commands, latches addresses and serves ID, status, read, page
// program and sector erase against an on-chip flash array.
// ----------------------------------------------------------------------------
// Usage: one item is one byte transfer (mosi_byte_i plus last_byte_i, which
// marks the end of chip select). Pulse start while busy is low; the returned
// byte appears on miso_byte_o with done_o high for exactly one cycle, the
// cycle right after acceptance, and must be captured then - the block cannot
// be held off. An ordinary item passes through the registered read of the
// array and then the result (and, for page program, the write-back) cycle;
// busy is high in that result cycle, so the next item is taken only after it.
// A sector erase adds a sweep of up to 4096 bytes, one byte per cycle
// through the array's write port, and the return to idle, during all of which busy stays high.
// After reset the array is cleared to 0xFF by a sweep over all FLASH_BYTES
// bytes; items are refused until the sweep has ended, register writes are
// taken throughout. device_id sits at APB byte address 0; pready is tied high.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_nor_flash_slave_unit import sfs_pkg::*; #(
  parameter int unsigned FLASH_BYTES = 2097152
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // item channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  mosi_byte_i,
  input  wire logic        last_byte_i,
  output logic             done_o,
  output logic [7:0]       miso_byte_o,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned AW = $clog2(FLASH_BYTES);
  localparam logic [25:0] FlashEnd = 26'(FLASH_BYTES);

  sfs_state_e state_q, state_d;

  // transaction state
  logic [7:0]  cmd_q, cmd_d;
  logic [24:0] off_q, off_d;
  logic [23:0] addr_q, addr_d;
  logic        in_tx_q, in_tx_d;
  logic        wren_q, wren_d;
  logic [23:0] dev_id_q;

  // per-item result state
  logic          resp_mem_q, resp_mem_d;
  logic          pp_q, pp_d;
  logic          se_q, se_d;
  logic [7:0]    resp_q, resp_d;
  logic [7:0]    byte_q;
  logic [AW-1:0] waddr_q;
  logic [AW-1:0] se_base_q;

  logic          accept;
  logic          cfg_wr;
  sfs_ctl_t      ctl;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  logic          fill_busy;

  // address arithmetic
  logic [25:0]   rd_sum;
  logic [7:0]    pp_low;
  logic [23:0]   pp_addr;
  logic [23:0]   addr_lat;
  logic [23:0]   se_addr;
  logic          rd_hit, pp_hit, se_hit, in_data;

  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;

  assign in_data  = off_q > 25'd2;
  assign rd_sum   = {2'b00, addr_q} + {1'b0, off_q} - 26'd3;
  assign pp_low   = addr_q[7:0] + off_q[7:0] - 8'd3;
  assign pp_addr  = (addr_q & PAGE_MASK) | {16'h0000, pp_low};
  assign se_addr  = addr_lat & SECTOR_MASK;

  // address byte latch, most significant first
  always_comb begin
    case (off_q[1:0])
      2'd0:    addr_lat = addr_q | {mosi_byte_i, 16'h0000};
      2'd1:    addr_lat = addr_q | {8'h00, mosi_byte_i, 8'h00};
      default: addr_lat = addr_q | {16'h0000, mosi_byte_i};
    endcase
  end

  assign rd_hit = in_tx_q && (cmd_q == CMD_READ) && in_data && (rd_sum < FlashEnd);
  assign pp_hit = in_tx_q && (cmd_q == CMD_PP) && in_data && wren_q &&
                  ({2'b00, pp_addr} < FlashEnd);
  assign se_hit = in_tx_q && (cmd_q == CMD_SE) && (off_q == 25'd2) && wren_q &&
                  ({2'b00, se_addr} < FlashEnd);

  assign raddr = (cmd_q == CMD_READ) ? rd_sum[AW-1:0] : pp_addr[AW-1:0];

  // next transaction state and result for an accepted item
  always_comb begin
    cmd_d      = cmd_q;
    off_d      = off_q;
    addr_d     = addr_q;
    in_tx_d    = in_tx_q;
    wren_d     = wren_q;
    resp_d     = ERASED_BYTE;
    resp_mem_d = 1'b0;
    pp_d       = 1'b0;
    se_d       = 1'b0;
    if (!in_tx_q) begin
      if (mosi_byte_i == CMD_WREN) begin
        wren_d = 1'b1;
      end else begin
        cmd_d   = mosi_byte_i;
        off_d   = '0;
        addr_d  = '0;
        in_tx_d = !last_byte_i;
      end
    end else begin
      case (cmd_q)
        CMD_RDID: begin
          if (!in_data) begin
            case (off_q[1:0])
              2'd0:    resp_d = dev_id_q[23:16];
              2'd1:    resp_d = dev_id_q[15:8];
              default: resp_d = dev_id_q[7:0];
            endcase
          end
        end
        CMD_READ: begin
          if (!in_data) begin
            addr_d = addr_lat;
          end
          resp_mem_d = rd_hit;
        end
        CMD_PP: begin
          if (!in_data) begin
            addr_d = addr_lat;
          end
          pp_d = pp_hit;
          if (last_byte_i) begin
            wren_d = 1'b0;
          end
        end
        CMD_SE: begin
          addr_d = in_data ? (addr_q & SECTOR_MASK) : se_addr;
          se_d   = se_hit;
          if (se_hit) begin
            wren_d = 1'b0;
          end
        end
        CMD_RDSR: resp_d = STATUS_BYTE;
        default:  resp_d = ERASED_BYTE;
      endcase
      if (last_byte_i) begin
        in_tx_d = 1'b0;
        cmd_d   = '0;
        off_d   = '0;
      end else if (off_q < OFFSET_MAX) begin
        off_d = off_q + 25'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q      <= '0;
      off_q      <= '0;
      addr_q     <= '0;
      in_tx_q    <= 1'b0;
      wren_q     <= 1'b0;
      resp_mem_q <= 1'b0;
      pp_q       <= 1'b0;
      se_q       <= 1'b0;
      dev_id_q   <= DEVICE_ID_RST;
    end else begin
      if (accept) begin
        cmd_q      <= cmd_d;
        off_q      <= off_d;
        addr_q     <= addr_d;
        in_tx_q    <= in_tx_d;
        wren_q     <= wren_d;
        resp_mem_q <= resp_mem_d;
        pp_q       <= pp_d;
        se_q       <= se_d;
      end
      if (cfg_wr && (paddr[2] == REG_DEVICE_ID)) begin
        dev_id_q <= pwdata[23:0];
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      resp_q    <= resp_d;
      byte_q    <= mosi_byte_i;
      waddr_q   <= pp_addr[AW-1:0];
      se_base_q <= se_addr[AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_FILL;
    end else begin
      state_q <= state_d;
    end
  end

  // controller: read issued at acceptance, result, write-back and erase start next cycle
  always_comb begin
    state_d        = state_q;
    busy           = 1'b1;
    done_o         = 1'b0;
    ctl.rd_en      = 1'b0;
    ctl.wr_en      = 1'b0;
    ctl.fill_start = 1'b0;
    unique case (state_q)
      S_FILL: begin
        if (!fill_busy) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.rd_en = rd_hit || pp_hit;
          state_d   = S_RESP;
        end
      end
      S_RESP: begin
        done_o         = 1'b1;
        ctl.wr_en      = pp_q;
        ctl.fill_start = se_q;
        state_d        = se_q ? S_FILL : S_IDLE;
      end
      default: state_d = S_FILL;
    endcase
  end

  assign miso_byte_o = resp_mem_q ? rdata : resp_q;

  assign prdata = (paddr[2] == REG_DEVICE_ID) ? {8'h00, dev_id_q} : 32'h0000_0000;
  assign pready = 1'b1;

  sfs_store #(
    .Depth(FLASH_BYTES)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .raddr_i    (raddr),
    .waddr_i    (waddr_q),
    .wdata_i    (rdata & byte_q),
    .fill_base_i(se_base_q),
    .rdata_o    (rdata),
    .fill_busy_o(fill_busy)
  );

`ifndef SYNTH
  // every accepted item yields its result in the following cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("no result after accepted item");

  a_result_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept))
    else $error("result without accepted item");

  // program write-back never collides with a fill sweep
  a_no_wr_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.wr_en && fill_busy))
    else $error("store write during fill");

  a_busy_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_busy |-> busy)
    else $error("item accepted during fill");

  // an erase consumes the write enable
  a_erase_clears_wren: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.fill_start |-> !wren_q)
    else $error("write enable still set after erase");
`endif

endmodule : spi_nor_flash_slave_unit

`default_nettype wire
